### rtl/ekx_pkg.sv
// Types, constants and key-advance function for the evolving-key XOR byte cipher.
package ekx_pkg;

   localparam logic [31:0] KEY_ADVANCE_XOR = 32'hDF13_8530;
   localparam logic [7:0]  TWEAK_LIMIT     = 8'd127;
   localparam logic [7:0]  MAX_PLAIN_LEN   = 8'd127;
   localparam logic [7:0]  HIGH_BIT        = 8'h80;
   localparam logic [7:0]  LOW_MASK        = 8'h7F;

   localparam logic [1:0]  CSR_MESSAGE_KEY  = 2'd0;
   localparam logic [1:0]  CSR_DIRECTION    = 2'd1;
   localparam logic [1:0]  CSR_LENGTH_TWEAK = 2'd2;

   localparam logic        DIR_ENCRYPT = 1'b0;
   localparam logic        DIR_DECRYPT = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] data_in;
      logic       first_byte;
      logic       last_byte;
      logic [7:0] message_length;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       is_trailer;
      logic       end_of_run;
      logic       rejected;
   } rsp_type;

   typedef struct packed {
      logic [31:0] message_key;
      logic        direction;
      logic        length_tweak;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic two;
   } push_type;

   function automatic logic [31:0] advance_key(input logic [31:0] k);
      logic [31:0] x;
      logic [31:0] r;
      x = k ^ KEY_ADVANCE_XOR;
      for (int i = 0; i < 4; i++) begin
         r[8*i +: 8] = x[8*i +: 8] | {x[8*i +: 7], 1'b0};
      end
      return r;
   endfunction

endpackage

### rtl/ekx_datapath.sv
// Running key state and single-pass byte transform with trailer generation.
module ekx_datapath import ekx_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     accept,
   input  req_type  item,
   output rsp_type  byte_rsp,
   output rsp_type  trailer_rsp
);

   logic [31:0] running_key_ff, running_key_in;
   logic [1:0]  key_index_ff, key_index_in;
   logic [31:0] base_key;
   logic [1:0]  base_index;
   logic [7:0]  key_byte;
   logic [7:0]  used_key;
   logic [7:0]  result;
   logic        reject;

   always_comb begin
      base_key   = item.first_byte ? cfg.message_key : running_key_ff;
      base_index = item.first_byte ? 2'd0 : key_index_ff;
      key_byte   = base_key[8*base_index +: 8];
      reject     = cfg.length_tweak && (item.message_length > MAX_PLAIN_LEN);
      used_key   = (cfg.length_tweak && (key_byte >= TWEAK_LIMIT))
                   ? (key_byte ^ ~item.message_length) : key_byte;
      if (cfg.direction == DIR_ENCRYPT) begin
         result = (item.data_in | HIGH_BIT) ^ used_key;
      end else begin
         result = (item.data_in ^ used_key) & LOW_MASK;
      end

      byte_rsp.data_out   = reject ? 8'd0 : result;
      byte_rsp.is_trailer = 1'b0;
      byte_rsp.end_of_run = !item.last_byte;
      byte_rsp.rejected   = reject;

      trailer_rsp.data_out   = (cfg.direction == DIR_ENCRYPT) ? item.message_length : 8'd0;
      trailer_rsp.is_trailer = 1'b1;
      trailer_rsp.end_of_run = 1'b1;
      trailer_rsp.rejected   = reject;

      // advance the key after every fourth byte
      running_key_in = running_key_ff;
      key_index_in   = key_index_ff;
      if (accept) begin
         running_key_in = (base_index == 2'd3) ? advance_key(base_key) : base_key;
         key_index_in   = base_index + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_key_ff <= '0;
         key_index_ff   <= '0;
      end else begin
         running_key_ff <= running_key_in;
         key_index_ff   <= key_index_in;
      end
   end

endmodule

### rtl/ekx_out_queue.sv
// Small result queue that takes one or two results per cycle and drains one.
module ekx_out_queue import ekx_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  rsp_type  first_rsp,
   input  rsp_type  second_rsp,
   output logic     room_for_two,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   rsp_type            q_ff [QUEUE_DEPTH];
   rsp_type            q_in [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_next;
   logic [CNT_W-1:0]   push_count;
   logic               pop;

   always_comb begin
      rsp_valid    = (count_ff != '0);
      rsp_data     = q_ff[rd_ptr_ff];
      room_for_two = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));
      pop          = rsp_valid && rsp_ready;
      wr_next      = wr_ptr_ff + PTR_W'(1);

      push_count = '0;
      if (push.valid) begin
         push_count = push.two ? CNT_W'(2) : CNT_W'(1);
      end

      q_in = q_ff;
      if (push.valid) begin
         q_in[wr_ptr_ff] = first_rsp;
         if (push.two) begin
            q_in[wr_next] = second_rsp;
         end
      end

      wr_ptr_in = wr_ptr_ff + PTR_W'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + push_count - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/evolving_key_xor_byte_cipher_core.sv
// Each result is registered in the result queue at its byte transfer; a trailer follows it.
// Throughput: one byte per cycle while the queue has room for two results; a last
// byte yields two results, so the result side sets the pace.
// A four-entry result queue lets input transfers continue while results wait.
// Synchronous reset clears the key state, the queue and the registers to
// message_key 0, direction encrypt, length_tweak on.
module evolving_key_xor_byte_cipher_core import ekx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   cfg_type  cfg_ff, cfg_in;
   logic     accept;
   push_type push;
   rsp_type  byte_rsp;
   rsp_type  trailer_rsp;
   logic     room_for_two;

   assign csr_ready  = 1'b1;
   assign req_ready  = room_for_two;
   assign accept     = req_valid && req_ready;
   assign push.valid = accept;
   assign push.two   = req_data.last_byte;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MESSAGE_KEY:  cfg_in.message_key  = csr_data;
            CSR_DIRECTION:    cfg_in.direction    = csr_data[0];
            CSR_LENGTH_TWEAK: cfg_in.length_tweak = csr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.message_key  <= '0;
         cfg_ff.direction    <= DIR_ENCRYPT;
         cfg_ff.length_tweak <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ekx_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .accept      (accept),
      .item        (req_data),
      .byte_rsp    (byte_rsp),
      .trailer_rsp (trailer_rsp)
   );

   ekx_out_queue u_out_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .first_rsp    (byte_rsp),
      .second_rsp   (trailer_rsp),
      .room_for_two (room_for_two),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

### verif/tb_evolving_key_xor_byte_cipher_core.sv
// Self-checking testbench for the evolving-key XOR byte cipher core.
module tb_evolving_key_xor_byte_cipher_core;
   import ekx_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 175;

   // Predicts the cipher results and holds them until they come out.
   class ekx_scoreboard;
      logic [31:0] key_reg   = '0;
      logic        dir_reg   = DIR_ENCRYPT;
      logic        tweak_reg = 1'b1;
      logic [31:0] live_key  = '0;
      logic [1:0]  byte_sel  = '0;
      rsp_type     expected_q[$];

      function void write_reg(input logic [1:0] idx, input logic [31:0] val);
         case (idx)
            CSR_MESSAGE_KEY:  key_reg   = val;
            CSR_DIRECTION:    dir_reg   = val[0];
            CSR_LENGTH_TWEAK: tweak_reg = val[0];
            default: ;
         endcase
      endfunction

      // XOR with the advance constant, then smear each byte one bit upward.
      function logic [31:0] stepped_key(input logic [31:0] k);
         logic [31:0] x;
         logic [31:0] r;
         logic [7:0]  b;
         x = k ^ KEY_ADVANCE_XOR;
         for (int i = 0; i < 4; i++) begin
            b = x[8*i +: 8];
            r[8*i +: 8] = b | (b << 1);
         end
         return r;
      endfunction

      function void note_byte(input req_type item);
         logic [7:0] kb;
         logic [7:0] out_byte;
         logic       rej;
         rsp_type    r;
         if (item.first_byte) begin
            live_key = key_reg;
            byte_sel = '0;
         end
         kb  = live_key[8*byte_sel +: 8];
         rej = tweak_reg && (item.message_length > MAX_PLAIN_LEN);
         if (tweak_reg && kb >= TWEAK_LIMIT)
            kb = kb ^ ~item.message_length;
         if (dir_reg == DIR_ENCRYPT)
            out_byte = (item.data_in | HIGH_BIT) ^ kb;
         else
            out_byte = (item.data_in ^ kb) & LOW_MASK;
         if (rej)
            out_byte = '0;
         if (byte_sel == 2'd3)
            live_key = stepped_key(live_key);
         byte_sel = byte_sel + 2'd1;

         r.data_out   = out_byte;
         r.is_trailer = 1'b0;
         r.end_of_run = !item.last_byte;
         r.rejected   = rej;
         expected_q.push_back(r);
         if (item.last_byte) begin
            r.data_out   = (dir_reg == DIR_ENCRYPT) ? item.message_length : 8'd0;
            r.is_trailer = 1'b1;
            r.end_of_run = 1'b1;
            expected_q.push_back(r);
         end
      endfunction

      // Returns an empty string when the result matches the oldest expectation.
      function string check_result(input rsp_type got);
         rsp_type want;
         string   why;
         if (expected_q.size() == 0)
            return $sformatf("unexpected result %h", got);
         want = expected_q.pop_front();
         why  = "";
         if (got.data_out !== want.data_out)
            why = {why, $sformatf(" data_out %h want %h", got.data_out, want.data_out)};
         if (got.is_trailer !== want.is_trailer)
            why = {why, $sformatf(" is_trailer %b want %b", got.is_trailer, want.is_trailer)};
         if (got.end_of_run !== want.end_of_run)
            why = {why, $sformatf(" end_of_run %b want %b", got.end_of_run, want.end_of_run)};
         if (got.rejected !== want.rejected)
            why = {why, $sformatf(" rejected %b want %b", got.rejected, want.rejected)};
         return why;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   ekx_scoreboard sb = new;
   int  mismatches = 0;
   bit  rx_burst   = 1'b0;
   int  long_hold  = 0;

   evolving_key_xor_byte_cipher_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("MISMATCH at %0t:%s", $time, what);
   endtask

   function automatic req_type make_byte(input logic [7:0] data, input logic first,
                                         input logic last, input logic [7:0] len);
      req_type item;
      item.data_in        = data;
      item.first_byte     = first;
      item.last_byte      = last;
      item.message_length = len;
      return item;
   endfunction

   // Hold valid until the transfer; leave it high so the next byte can follow directly.
   task automatic send_byte(input req_type item, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(item);
   endtask

   // Drop valid and wait until every expected result has come out.
   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed messages with random content, some with a wrong length,
   // and a share of bytes with random framing flags.
   task automatic random_traffic(input int n_items);
      int      sent;
      int      nbytes;
      int      gap;
      bit      tx_burst;
      bit      framed;
      logic [7:0] len;
      req_type item;
      sent = 0;
      while (sent < n_items) begin
         tx_burst = ($urandom_range(0, 3) == 0);
         rx_burst = ($urandom_range(0, 3) == 0);
         framed   = ($urandom_range(0, 9) < 8);
         if ($urandom_range(0, 7) == 0)
            nbytes = $urandom_range(9, 40);
         else
            nbytes = $urandom_range(1, 8);
         len = 8'(nbytes);
         if ($urandom_range(0, 5) == 0)
            len = 8'($urandom);
         for (int i = 0; i < nbytes; i++) begin
            if (framed)
               item = make_byte(8'($urandom), i == 0, i == nbytes - 1, len);
            else
               item = make_byte(8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
            gap = tx_burst ? 0 : $urandom_range(0, 7);
            send_byte(item, gap);
         end
         sent += nbytes;
      end
   endtask

   // Result side: random stalls, an occasional long hold-off, check every transfer.
   initial begin
      int    stall;
      string why;
      while (reset) @(posedge clock);
      forever begin
         stall = rx_burst ? 0 : $urandom_range(0, 7);
         if (long_hold > 0) begin
            stall     = long_hold;
            long_hold = 0;
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         why = sb.check_result(rsp_data);
         if (why != "")
            report_mismatch(why);
      end
   end

   // Watchdog: end the run after too many cycles without any transfer.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      logic [31:0] key;
      logic        dir_sel;
      logic        tweak_sel;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings, no first byte seen yet: the reset key is used as it stands.
      send_byte(make_byte(8'h00, 1'b0, 1'b0, 8'd5), 0);
      send_byte(make_byte(8'hFF, 1'b0, 1'b0, 8'd5), 1);
      wait_until_drained();

      // Key bytes 0x00, 0x7E, 0x7F, 0xFF straddle the tweak threshold.
      write_csr(CSR_MESSAGE_KEY, 32'hFF7F_7E00);
      send_byte(make_byte(8'h00, 1'b1, 1'b1, 8'd1), 0);
      send_byte(make_byte(8'hFF, 1'b1, 1'b0, 8'd4), 0);
      send_byte(make_byte(8'h00, 1'b0, 1'b0, 8'd4), 0);
      send_byte(make_byte(8'h7F, 1'b0, 1'b0, 8'd4), 2);
      send_byte(make_byte(8'h80, 1'b0, 1'b1, 8'd4), 0);
      // Longest accepted length, running across a key advance.
      send_byte(make_byte(8'h55, 1'b1, 1'b0, 8'd127), 0);
      send_byte(make_byte(8'hAA, 1'b0, 1'b0, 8'd127), 0);
      send_byte(make_byte(8'h01, 1'b0, 1'b0, 8'd127), 0);
      send_byte(make_byte(8'hFE, 1'b0, 1'b0, 8'd127), 0);
      send_byte(make_byte(8'h33, 1'b0, 1'b1, 8'd127), 0);
      // Rejected lengths, and a zero length.
      send_byte(make_byte(8'h12, 1'b1, 1'b0, 8'd128), 0);
      send_byte(make_byte(8'h34, 1'b0, 1'b1, 8'd128), 0);
      send_byte(make_byte(8'hFF, 1'b1, 1'b1, 8'd255), 3);
      send_byte(make_byte(8'h80, 1'b1, 1'b1, 8'd0), 0);

      for (int p = 0; p < PHASES; p++) begin
         wait_until_drained();
         if (p == 1 || p == 5)
            key = 32'hFFFF_FFFF;
         else if (p == 0 || p == 6)
            key = 32'h0000_0000;
         else if (p == 3)
            key = 32'h807F_7E01;
         else
            key = $urandom;
         dir_sel   = p[0] ? DIR_DECRYPT : DIR_ENCRYPT;
         tweak_sel = p[1];
         write_csr(CSR_MESSAGE_KEY, key);
         write_csr(CSR_DIRECTION, {31'd0, dir_sel});
         write_csr(CSR_LENGTH_TWEAK, {31'd0, tweak_sel});
         // Stall the result side long enough for the block to back up.
         if (p == 2 || p == 5)
            long_hold = 80;
         random_traffic(PHASE_ITEMS);
      end

      wait_until_drained();
      repeat (8) @(posedge clock);
      if (sb.pending() != 0)
         report_mismatch($sformatf(" %0d results never arrived", sb.pending()));
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

### sim.f
rtl/ekx_pkg.sv
rtl/ekx_datapath.sv
rtl/ekx_out_queue.sv
rtl/evolving_key_xor_byte_cipher_core.sv
verif/tb_evolving_key_xor_byte_cipher_core.sv
